// ----- hdl/tvgs_pkg.sv -----
// Shared types, constants and a helper function for the trilinear vector grid sampler.
`timescale 1ns / 1ps
`default_nettype none
package tvgs_pkg;
    localparam int GRID_SIZE = 16;
    localparam int IDX_W = $clog2(GRID_SIZE);
    localparam int BANK_IDX_W = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int BANK_DEPTH = (GRID_SIZE / 2) * (GRID_SIZE / 2) * (GRID_SIZE / 2);
    localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CELL_W = 4;
    localparam int COMP_W = 16;
    localparam int VEC_W = 3 * COMP_W;
    localparam int POS_W = 16;
    localparam int FRAC_W = 8;
    localparam int PSUM_W = POS_W + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;
    localparam logic signed [PSUM_W-1:0] POS_OFFSET =
        PSUM_W'((GRID_SIZE / 2) * 256);
    localparam logic signed [PSUM_W-1:0] POS_LIMIT =
        PSUM_W'((GRID_SIZE - 1) * 256);

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    typedef struct packed {
        logic                  is_write;
        logic                  in_range;
        logic [IDX_W-1:0]      ix;
        logic [IDX_W-1:0]      iy;
        logic [IDX_W-1:0]      iz;
        logic [FRAC_W-1:0]     fx;
        logic [FRAC_W-1:0]     fy;
        logic [FRAC_W-1:0]     fz;
        logic [VEC_W-1:0]      wdata;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    function automatic logic signed [COMP_W-1:0] lerp(
        input logic signed [COMP_W-1:0] a,
        input logic signed [COMP_W-1:0] b,
        input logic [FRAC_W-1:0] t
    );
        logic signed [COMP_W:0] d;
        logic signed [COMP_W+FRAC_W+1:0] p;
        logic signed [COMP_W+1:0] s;
        begin
            d = (COMP_W+1)'(b) - (COMP_W+1)'(a);
            p = d * $signed({1'b0, t});
            s = (COMP_W+2)'(a) + (COMP_W+2)'(p >>> FRAC_W);
            lerp = s[COMP_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ----- hdl/tvgs_front.sv -----
// Front end: classifies beats, checks sample range and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module tvgs_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire                          i_action,
    input  wire [tvgs_pkg::CELL_W-1:0]   i_cell_x,
    input  wire [tvgs_pkg::CELL_W-1:0]   i_cell_y,
    input  wire [tvgs_pkg::CELL_W-1:0]   i_cell_z,
    input  wire [tvgs_pkg::COMP_W-1:0]   i_value_x,
    input  wire [tvgs_pkg::COMP_W-1:0]   i_value_y,
    input  wire [tvgs_pkg::COMP_W-1:0]   i_value_z,
    input  wire [tvgs_pkg::POS_W-1:0]    i_pos_x,
    input  wire [tvgs_pkg::POS_W-1:0]    i_pos_y,
    input  wire [tvgs_pkg::POS_W-1:0]    i_pos_z,
    output logic                         o_cmd_valid,
    output tvgs_pkg::t_cmd               o_cmd,
    input  wire                          i_cmd_pop
);
    tvgs_pkg::t_cmd                   r_q [tvgs_pkg::FIFO_DEPTH];
    logic [tvgs_pkg::FIFO_AW-1:0]     r_wp, r_rp;
    logic [tvgs_pkg::FIFO_AW:0]       r_cnt;
    tvgs_pkg::t_cmd                   n_cmd;
    logic                             w_push, w_pop, w_ok;
    logic signed [tvgs_pkg::PSUM_W-1:0] w_px, w_py, w_pz;

    always_comb begin
        w_px = tvgs_pkg::PSUM_W'($signed(i_pos_x)) + tvgs_pkg::POS_OFFSET;
        w_py = tvgs_pkg::PSUM_W'($signed(i_pos_y)) + tvgs_pkg::POS_OFFSET;
        w_pz = tvgs_pkg::PSUM_W'($signed(i_pos_z)) + tvgs_pkg::POS_OFFSET;
        n_cmd = '0;
        n_cmd.is_write = (i_action == tvgs_pkg::ACT_WRITE);
        if (n_cmd.is_write) begin
            w_ok = (32'(i_cell_x) < tvgs_pkg::GRID_SIZE)
                && (32'(i_cell_y) < tvgs_pkg::GRID_SIZE)
                && (32'(i_cell_z) < tvgs_pkg::GRID_SIZE);
            n_cmd.in_range = w_ok;
            n_cmd.ix = tvgs_pkg::IDX_W'(i_cell_x);
            n_cmd.iy = tvgs_pkg::IDX_W'(i_cell_y);
            n_cmd.iz = tvgs_pkg::IDX_W'(i_cell_z);
            n_cmd.wdata = {i_value_x, i_value_y, i_value_z};
        end else begin
            w_ok = (w_px >= 0) && (w_px < tvgs_pkg::POS_LIMIT)
                && (w_py >= 0) && (w_py < tvgs_pkg::POS_LIMIT)
                && (w_pz >= 0) && (w_pz < tvgs_pkg::POS_LIMIT);
            n_cmd.in_range = w_ok;
            n_cmd.ix = w_px[tvgs_pkg::FRAC_W +: tvgs_pkg::IDX_W];
            n_cmd.iy = w_py[tvgs_pkg::FRAC_W +: tvgs_pkg::IDX_W];
            n_cmd.iz = w_pz[tvgs_pkg::FRAC_W +: tvgs_pkg::IDX_W];
            n_cmd.fx = w_px[tvgs_pkg::FRAC_W-1:0];
            n_cmd.fy = w_py[tvgs_pkg::FRAC_W-1:0];
            n_cmd.fz = w_pz[tvgs_pkg::FRAC_W-1:0];
        end
    end

    assign o_busy = (r_cnt == (tvgs_pkg::FIFO_AW+1)'(tvgs_pkg::FIFO_DEPTH));
    assign w_push = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop = i_cmd_pop && o_cmd_valid;
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (tvgs_pkg::FIFO_AW+1)'(w_push)
                - (tvgs_pkg::FIFO_AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

// ----- hdl/tvgs_bank.sv -----
// One parity bank of the vector grid with one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tvgs_bank (
    input  wire                            i_clk,
    input  wire                            i_we,
    input  wire [tvgs_pkg::BANK_AW-1:0]    i_waddr,
    input  wire [tvgs_pkg::VEC_W-1:0]      i_wdata,
    input  wire [tvgs_pkg::BANK_AW-1:0]    i_raddr,
    output logic [tvgs_pkg::VEC_W-1:0]     o_rdata
);
    logic [tvgs_pkg::VEC_W-1:0] r_mem [tvgs_pkg::BANK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/tvgs_back.sv -----
// Back end: eight parity banks and a pipelined z, y, x interpolation chain.
`timescale 1ns / 1ps
`default_nettype none
module tvgs_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cmd_valid,
    input  wire tvgs_pkg::t_cmd          i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_valid,
    output logic [tvgs_pkg::COMP_W-1:0]  o_out_x,
    output logic [tvgs_pkg::COMP_W-1:0]  o_out_y,
    output logic [tvgs_pkg::COMP_W-1:0]  o_out_z,
    output logic                         o_in_range
);
    localparam int BW = tvgs_pkg::BANK_IDX_W;
    localparam int CW = tvgs_pkg::COMP_W;

    logic [tvgs_pkg::IDX_W-1:0] w_cx [2];
    logic [tvgs_pkg::IDX_W-1:0] w_cy [2];
    logic [tvgs_pkg::IDX_W-1:0] w_cz [2];
    logic [tvgs_pkg::VEC_W-1:0] w_rd [8];
    logic                       w_wr;

    // Stage registers.
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_r1, r_r2, r_r3;
    logic [2:0] r_par1;
    logic [tvgs_pkg::FRAC_W-1:0] r_fx1, r_fy1, r_fz1, r_fx2, r_fy2, r_fx3;
    logic signed [CW-1:0] r_e [3][4];
    logic signed [CW-1:0] r_g [3][2];

    assign o_cmd_pop = i_cmd_valid;
    assign w_wr = i_cmd_valid && i_cmd.is_write && i_cmd.in_range;

    always_comb begin
        w_cx[0] = i_cmd.ix;
        w_cy[0] = i_cmd.iy;
        w_cz[0] = i_cmd.iz;
        w_cx[1] = i_cmd.ix + 1'b1;
        w_cy[1] = i_cmd.iy + 1'b1;
        w_cz[1] = i_cmd.iz + 1'b1;
    end

    // Bank b holds cells whose x, y, z parities are b[2], b[1], b[0].
    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [tvgs_pkg::IDX_W-1:0] w_ax, w_ay, w_az;
        logic [tvgs_pkg::BANK_AW-1:0] w_ra, w_wa;
        logic w_hit;
        always_comb begin
            w_ax = (w_cx[0][0] == b[2]) ? w_cx[0] : w_cx[1];
            w_ay = (w_cy[0][0] == b[1]) ? w_cy[0] : w_cy[1];
            w_az = (w_cz[0][0] == b[0]) ? w_cz[0] : w_cz[1];
            w_ra = tvgs_pkg::BANK_AW'({w_ax[tvgs_pkg::IDX_W-1 -: BW],
                w_ay[tvgs_pkg::IDX_W-1 -: BW], w_az[tvgs_pkg::IDX_W-1 -: BW]});
            w_wa = tvgs_pkg::BANK_AW'({i_cmd.ix[tvgs_pkg::IDX_W-1 -: BW],
                i_cmd.iy[tvgs_pkg::IDX_W-1 -: BW], i_cmd.iz[tvgs_pkg::IDX_W-1 -: BW]});
            w_hit = ({i_cmd.ix[0], i_cmd.iy[0], i_cmd.iz[0]} == 3'(b));
        end
        tvgs_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (w_wr && w_hit),
            .i_waddr (w_wa),
            .i_wdata (i_cmd.wdata),
            .i_raddr (w_ra),
            .o_rdata (w_rd[b])
        );
    end

    always_ff @(posedge i_clk) begin
        r_par1 <= {i_cmd.ix[0], i_cmd.iy[0], i_cmd.iz[0]};
        r_fx1 <= i_cmd.fx;
        r_fy1 <= i_cmd.fy;
        r_fz1 <= i_cmd.fz;
        r_r1 <= i_cmd.in_range;
        r_fx2 <= r_fx1;
        r_fy2 <= r_fy1;
        r_r2 <= r_r1;
        r_fx3 <= r_fx2;
        r_r3 <= r_r2;
        for (int c = 0; c < 3; c++) begin
            for (int dx = 0; dx < 2; dx++) begin
                for (int dy = 0; dy < 2; dy++) begin
                    r_e[c][dx*2+dy] <= tvgs_pkg::lerp(
                        w_rd[{r_par1[2] ^ dx[0], r_par1[1] ^ dy[0], r_par1[0]}]
                            [(2-c)*CW +: CW],
                        w_rd[{r_par1[2] ^ dx[0], r_par1[1] ^ dy[0], ~r_par1[0]}]
                            [(2-c)*CW +: CW],
                        r_fz1);
                end
            end
            r_g[c][0] <= tvgs_pkg::lerp(r_e[c][0], r_e[c][1], r_fy2);
            r_g[c][1] <= tvgs_pkg::lerp(r_e[c][2], r_e[c][3], r_fy2);
        end
        if (r_r3) begin
            o_out_x <= tvgs_pkg::lerp(r_g[0][0], r_g[0][1], r_fx3);
            o_out_y <= tvgs_pkg::lerp(r_g[1][0], r_g[1][1], r_fx3);
            o_out_z <= tvgs_pkg::lerp(r_g[2][0], r_g[2][1], r_fx3);
        end else begin
            o_out_x <= '0;
            o_out_y <= '0;
            o_out_z <= '0;
        end
        o_in_range <= r_r3;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd_valid && !i_cmd.is_write;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
endmodule
`default_nettype wire

// ----- hdl/trilinear_vector_grid_sampler.sv -----
// Top level of the trilinear vector grid sampler.
// A sample beat passes through the command queue, the registered bank read and the z, y and x interpolation registers.
// One beat is accepted per cycle; the eight parity banks give all corners in one read.
// busy rises only if the four-entry command queue fills.
// Synchronous active-low reset empties the queue and the pipeline; grid contents persist.
// The receiver cannot stall: each result shows on o_done for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module trilinear_vector_grid_sampler (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire                         i_action,
    input  wire [tvgs_pkg::CELL_W-1:0]  i_cell_x,
    input  wire [tvgs_pkg::CELL_W-1:0]  i_cell_y,
    input  wire [tvgs_pkg::CELL_W-1:0]  i_cell_z,
    input  wire [tvgs_pkg::COMP_W-1:0]  i_value_x,
    input  wire [tvgs_pkg::COMP_W-1:0]  i_value_y,
    input  wire [tvgs_pkg::COMP_W-1:0]  i_value_z,
    input  wire [tvgs_pkg::POS_W-1:0]   i_pos_x,
    input  wire [tvgs_pkg::POS_W-1:0]   i_pos_y,
    input  wire [tvgs_pkg::POS_W-1:0]   i_pos_z,
    output logic                        o_done,
    output logic [tvgs_pkg::COMP_W-1:0] o_out_x,
    output logic [tvgs_pkg::COMP_W-1:0] o_out_y,
    output logic [tvgs_pkg::COMP_W-1:0] o_out_z,
    output logic                        o_in_range
);
    logic           w_cmd_valid, w_pop;
    tvgs_pkg::t_cmd w_cmd;

    tvgs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_action(i_action), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_cell_z(i_cell_z), .i_value_x(i_value_x), .i_value_y(i_value_y),
        .i_value_z(i_value_z), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd),
        .i_cmd_pop(w_pop)
    );

    tvgs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid),
        .i_cmd(w_cmd), .o_cmd_pop(w_pop), .o_valid(o_done),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_in_range(o_in_range)
    );
endmodule
`default_nettype wire

// ----- hdl/tvgs_checker.sv -----
// Port-level checker for the trilinear vector grid sampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tvgs_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         start,
    input wire                         busy,
    input wire                         i_action,
    input wire                         o_done,
    input wire [tvgs_pkg::COMP_W-1:0]  o_out_x,
    input wire [tvgs_pkg::COMP_W-1:0]  o_out_y,
    input wire [tvgs_pkg::COMP_W-1:0]  o_out_z,
    input wire                         o_in_range
);
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_in_range |-> o_out_x == '0 && o_out_y == '0 && o_out_z == '0)
        else $error("out-of-range result is not zero");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !busy)
        else $error("activity right after reset");
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_action && !$past(busy) |-> ##1 !busy)
        else $error("busy rose with an empty queue");
    a_no_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(start) && !$past(busy) |-> !busy)
        else $error("busy without traffic");
endmodule

bind trilinear_vector_grid_sampler tvgs_checker u_tvgs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_action(i_action), .o_done(o_done), .o_out_x(o_out_x),
    .o_out_y(o_out_y), .o_out_z(o_out_z), .o_in_range(o_in_range)
);
`default_nettype wire

// ----- test/trilinear_vector_grid_sampler_tb.sv -----
// Self-checking testbench for the trilinear vector grid sampler: directed table, then random beats.
`timescale 1ns / 1ps
`default_nettype none
module trilinear_vector_grid_sampler_tb;
    typedef struct {
        logic        act;
        logic [3:0]  cx, cy, cz;
        logic [15:0] vx, vy, vz;
        logic [15:0] px, py, pz;
        logic        known;
        logic [15:0] ex, ey, ez;
        logic        er;
    } t_row;

    typedef struct {
        logic [15:0] vx, vy, vz;
        logic        rng;
    } t_sample_result;

    localparam int N_DIR = 22;
    localparam int N_RAND = 650;
    localparam int GS = tvgs_pkg::GRID_SIZE;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_action = 1'b0;
    logic [3:0] i_cell_x = '0, i_cell_y = '0, i_cell_z = '0;
    logic [15:0] i_value_x = '0, i_value_y = '0, i_value_z = '0;
    logic [15:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic o_done;
    logic [15:0] o_out_x, o_out_y, o_out_z;
    logic o_in_range;

    logic signed [15:0] grid_model [GS][GS][GS][3];
    bit written [GS][GS][GS];
    t_sample_result pending_samples[$];
    t_row dir_rows[N_DIR];
    int errors = 0;
    int n_samples = 0;
    int n_in_range = 0;
    bit no_idle = 1'b0;

    always #6 i_clk = ~i_clk;

    trilinear_vector_grid_sampler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_cell_z(i_cell_z), .i_value_x(i_value_x), .i_value_y(i_value_y),
        .i_value_z(i_value_z), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .o_done(o_done), .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_out_z(o_out_z), .o_in_range(o_in_range)
    );

    function automatic int blend(int a, int b, int t);
        int p;
        p = (b - a) * t;
        return a + (p >>> 8);
    endfunction

    function automatic t_sample_result interpolate(logic [15:0] px, logic [15:0] py,
                                                   logic [15:0] pz);
        t_sample_result r;
        int p[3], ix[3], fr[3];
        int e[2][2];
        int r0, r1, v;
        p[0] = int'($signed(px)) + (GS / 2) * 256;
        p[1] = int'($signed(py)) + (GS / 2) * 256;
        p[2] = int'($signed(pz)) + (GS / 2) * 256;
        r = '{16'd0, 16'd0, 16'd0, 1'b0};
        for (int k = 0; k < 3; k++) begin
            if (p[k] < 0 || p[k] >= (GS - 1) * 256) return r;
            ix[k] = p[k] >>> 8;
            fr[k] = p[k] & 255;
        end
        for (int c = 0; c < 3; c++) begin
            for (int dx = 0; dx < 2; dx++)
                for (int dy = 0; dy < 2; dy++)
                    e[dx][dy] = blend(grid_model[ix[0]+dx][ix[1]+dy][ix[2]][c],
                                      grid_model[ix[0]+dx][ix[1]+dy][ix[2]+1][c], fr[2]);
            r0 = blend(e[0][0], e[0][1], fr[1]);
            r1 = blend(e[1][0], e[1][1], fr[1]);
            v = blend(r0, r1, fr[0]);
            if (c == 0) r.vx = v[15:0];
            else if (c == 1) r.vy = v[15:0];
            else r.vz = v[15:0];
        end
        r.rng = 1'b1;
        return r;
    endfunction

    function automatic bit corners_written(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
        int p[3], ix[3];
        p[0] = int'($signed(px)) + (GS / 2) * 256;
        p[1] = int'($signed(py)) + (GS / 2) * 256;
        p[2] = int'($signed(pz)) + (GS / 2) * 256;
        for (int k = 0; k < 3; k++) begin
            if (p[k] < 0 || p[k] >= (GS - 1) * 256) return 1'b1;
            ix[k] = p[k] >>> 8;
        end
        for (int d = 0; d < 8; d++)
            if (!written[ix[0]+d[2]][ix[1]+d[1]][ix[2]+d[0]]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_beat(t_row row);
        t_sample_result r;
        while (!no_idle && $urandom_range(99) < 26) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= row.act;
        i_cell_x <= row.cx; i_cell_y <= row.cy; i_cell_z <= row.cz;
        i_value_x <= row.vx; i_value_y <= row.vy; i_value_z <= row.vz;
        i_pos_x <= row.px; i_pos_y <= row.py; i_pos_z <= row.pz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (row.act == tvgs_pkg::ACT_WRITE) begin
            grid_model[row.cx][row.cy][row.cz][0] = row.vx;
            grid_model[row.cx][row.cy][row.cz][1] = row.vy;
            grid_model[row.cx][row.cy][row.cz][2] = row.vz;
            written[row.cx][row.cy][row.cz] = 1'b1;
        end else begin
            if (row.known) r = '{row.ex, row.ey, row.ez, row.er};
            else r = interpolate(row.px, row.py, row.pz);
            pending_samples.push_back(r);
            n_samples++;
            if (r.rng) n_in_range++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sample_result w;
        if (i_rst_n && o_done) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                w = pending_samples.pop_front();
                if (o_out_x !== w.vx) begin
                    $error("out_x expected %h actual %h", w.vx, o_out_x); errors++;
                end
                if (o_out_y !== w.vy) begin
                    $error("out_y expected %h actual %h", w.vy, o_out_y); errors++;
                end
                if (o_out_z !== w.vz) begin
                    $error("out_z expected %h actual %h", w.vz, o_out_z); errors++;
                end
                if (o_in_range !== w.rng) begin
                    $error("in_range expected %b actual %b", w.rng, o_in_range); errors++;
                end
            end
        end
    end

    function automatic t_row wr(int x, int y, int z, int a, int b, int c);
        return '{tvgs_pkg::ACT_WRITE, x[3:0], y[3:0], z[3:0], a[15:0], b[15:0], c[15:0],
                 16'h0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0, 1'b0};
    endfunction

    function automatic t_row smp(int x, int y, int z, bit k, int a, int b, int c, bit g);
        return '{tvgs_pkg::ACT_SAMPLE, 4'hf, 4'hf, 4'hf, 16'hffff, 16'hffff, 16'hffff,
                 x[15:0], y[15:0], z[15:0], k, a[15:0], b[15:0], c[15:0], g};
    endfunction

    task automatic random_beat();
        t_row row;
        int sel;
        row = smp(0, 0, 0, 0, 0, 0, 0, 0);
        sel = $urandom_range(99);
        if (sel < 35) begin
            row = wr($urandom_range(15), $urandom_range(15), $urandom_range(15),
                     $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                     $urandom_range(32768) - 16384);
            if (sel < 4) begin
                row.vx = 16'($urandom); row.vy = 16'($urandom); row.vz = 16'($urandom);
            end
            row.px = 16'($urandom); row.py = 16'($urandom); row.pz = 16'($urandom);
        end else begin
            do begin
                if (sel < 85) begin
                    row.px = 16'($urandom_range(3839) - 2048);
                    row.py = 16'($urandom_range(3839) - 2048);
                    row.pz = 16'($urandom_range(3839) - 2048);
                end else begin
                    row.px = 16'($urandom); row.py = 16'($urandom); row.pz = 16'($urandom);
                end
            end while (!corners_written(row.px, row.py, row.pz));
            row.cx = 4'($urandom); row.cy = 4'($urandom); row.cz = 4'($urandom);
            row.vx = 16'($urandom); row.vy = 16'($urandom); row.vz = 16'($urandom);
        end
        send_beat(row);
    endtask

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        dir_rows = '{
            smp(-32768, 0, 0, 1, 0, 0, 0, 0),
            smp(0, 32767, 0, 1, 0, 0, 0, 0),
            smp(0, 0, -2049, 1, 0, 0, 0, 0),
            smp(1792, 0, 0, 1, 0, 0, 0, 0),
            wr(0, 0, 0, 16384, -16384, 0),
            wr(0, 0, 1, -16384, 16384, 32767),
            wr(0, 1, 0, 0, 0, -32768),
            wr(0, 1, 1, 100, -100, 1),
            wr(1, 0, 0, -1, 1, 16384),
            wr(1, 0, 1, 8192, -8192, -16384),
            wr(1, 1, 0, 16384, 16384, 16384),
            wr(1, 1, 1, -16384, -16384, -16384),
            wr(15, 15, 15, 16384, 16384, 16384),
            wr(14, 15, 15, -16384, -16384, -16384),
            smp(-2048, -2048, -2048, 1, 16384, -16384, 0, 1),
            smp(-2048, -2048, -2047, 0, 0, 0, 0, 0),
            smp(-1920, -1920, -1920, 0, 0, 0, 0, 0),
            smp(-1793, -1793, -1793, 0, 0, 0, 0, 0),
            smp(-2048, -2048, -1793, 0, 0, 0, 0, 0),
            wr(7, 7, 7, 1, 2, 3),
            smp(1791, 1791, 1791, 1, 0, 0, 0, 1),
            smp(1791, 1792, 1791, 1, 0, 0, 0, 0)
        };
        for (int x = 0; x < GS; x++)
            for (int y = 0; y < GS; y++)
                for (int z = 0; z < GS; z++)
                    written[x][y][z] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIR; i++) begin
            if (i == 20) begin
                for (int x = 14; x < 16; x++)
                    for (int y = 14; y < 16; y++)
                        for (int z = 14; z < 16; z++)
                            send_beat(wr(x, y, z, 0, 0, 0));
            end
            send_beat(dir_rows[i]);
        end
        start <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        for (int i = 0; i < N_RAND; i++) begin
            no_idle = (i >= 200 && i < 320);
            random_beat();
        end
        start <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Ran %0d directed and %0d random beats, %0d samples (%0d in range).",
                 N_DIR, N_RAND, n_samples, n_in_range);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
